@@ src/res_pkg.sv @@
package res_pkg;

	localparam int MaxRecordsDef = 64;

	// One stored record; the sort key is everything above the price payload.
	typedef struct packed {
		logic [63:0] author_high;
		logic [39:0] author_low;
		logic [63:0] title_high;
		logic [39:0] title_low;
		logic [63:0] price_bits;
	} rec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_in;      // write the input item at wr_addr
		logic wr_cur;     // write the held record at wr_addr
		logic swap_step;  // compare held record with read data, swap on greater
		logic rd_en;      // read the store at rd_addr
		logic cur_ld;     // load the held record from read data
		logic emit;       // present read data as a result
		logic emit_last;  // that result closes the set
	} cmd_t;

endpackage

@@ src/res_datapath.sv @@
module res_datapath #(
	parameter int MAX_RECORDS = res_pkg::MaxRecordsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  res_pkg::cmd_t                  cmd,
	input  logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
	input  logic [$clog2(MAX_RECORDS)-1:0] rd_addr,
	input  res_pkg::rec_t                  in_rec,
	output res_pkg::rec_t                  out_rec,
	output logic                           out_valid,
	output logic                           out_last
);
	import res_pkg::*;

	rec_t mem [MAX_RECORDS];
	rec_t rd_q;
	rec_t cur_q;
	logic gt;
	logic wr_en;
	rec_t wr_data;
	logic take;

	// Held record greater than the one just read: author first, then title.
	assign gt = {cur_q.author_high, cur_q.author_low, cur_q.title_high, cur_q.title_low} >
		{rd_q.author_high, rd_q.author_low, rd_q.title_high, rd_q.title_low};

	assign take    = cmd.swap_step & gt;
	assign wr_en   = cmd.wr_in | cmd.wr_cur | take;
	assign wr_data = cmd.wr_in ? in_rec : cur_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.cur_ld | take) begin
			cur_q <= rd_q;
		end
		if (cmd.emit) begin
			out_rec  <= rd_q;
			out_last <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= cmd.emit;
		end
	end

endmodule

@@ src/res_ctrl.sv @@
module res_ctrl #(
	parameter int MAX_RECORDS = res_pkg::MaxRecordsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           last_of_set,
	output logic                           busy,
	output res_pkg::cmd_t                  cmd,
	output logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
	output logic [$clog2(MAX_RECORDS)-1:0] rd_addr
);
	import res_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RDJ    = 3'd1;
	localparam logic [2:0] S_LDJ    = 3'd2;
	localparam logic [2:0] S_CMP    = 3'd3;
	localparam logic [2:0] S_WRJ    = 3'd4;
	localparam logic [2:0] S_OUT_RD = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] j_q, j_d;
	logic [AW-1:0] h_q, h_d;
	logic          room;

	assign room = fill_q < CW'(MAX_RECORDS);
	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		j_d     = j_q;
		h_d     = h_q;
		cmd     = '0;
		wr_addr = j_q;
		rd_addr = j_q;
		case (state_q)
			S_IDLE: begin
				wr_addr = fill_q[AW-1:0];
				if (start) begin
					j_d = '0;
					if (room) begin
						cmd.wr_in = 1'b1;
						fill_d    = fill_q + CW'(1);
					end
					if (last_of_set) begin
						state_d = (fill_d > CW'(1)) ? S_RDJ : S_OUT_RD;
					end
				end
			end
			S_RDJ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LDJ;
			end
			S_LDJ: begin
				cmd.cur_ld = 1'b1;
				cmd.rd_en  = 1'b1;
				rd_addr    = j_q + AW'(1);
				h_d        = j_q + AW'(1);
				state_d    = S_CMP;
			end
			S_CMP: begin
				cmd.swap_step = 1'b1;
				wr_addr       = h_q;
				if (CW'(h_q) + CW'(1) < fill_q) begin
					cmd.rd_en = 1'b1;
					rd_addr   = h_q + AW'(1);
					h_d       = h_q + AW'(1);
				end else begin
					state_d = S_WRJ;
				end
			end
			S_WRJ: begin
				cmd.wr_cur = 1'b1;
				wr_addr    = j_q;
				if (CW'(j_q) + CW'(2) < fill_q) begin
					cmd.rd_en = 1'b1;
					rd_addr   = j_q + AW'(1);
					j_d       = j_q + AW'(1);
					state_d   = S_LDJ;
				end else begin
					j_d     = '0;
					state_d = S_OUT_RD;
				end
			end
			S_OUT_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (CW'(j_q) + CW'(1) == fill_q) begin
					cmd.emit_last = 1'b1;
					fill_d        = '0;
					state_d       = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					rd_addr   = j_q + AW'(1);
					j_d       = j_q + AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			j_q     <= '0;
			h_q     <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			j_q     <= j_d;
			h_q     <= h_d;
		end
	end

endmodule

@@ src/record_exchange_sort.sv @@
// Loading: one item per cycle while busy is low; no results until the item marked last.
// Sort: skipped for a set of one; otherwise one compare per cycle on the store's single read port;
// then a read of the first record and one result per cycle, n in all, each through the output
// register; busy falls as the last result appears. Results cannot be stalled. Reset empties
// the set; the store contents are not cleared.
module record_exchange_sort #(
	parameter int MAX_RECORDS = res_pkg::MaxRecordsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] in_author_high,
	input  logic [39:0] in_author_low,
	input  logic [63:0] in_title_high,
	input  logic [39:0] in_title_low,
	input  logic [63:0] in_price_bits,
	input  logic        last_of_set,
	output logic        valid,
	output logic [63:0] out_author_high,
	output logic [39:0] out_author_low,
	output logic [63:0] out_title_high,
	output logic [39:0] out_title_low,
	output logic [63:0] out_price_bits,
	output logic        last_out
);
	import res_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);

	cmd_t          cmd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	rec_t          in_rec;
	rec_t          out_rec;

	// Pack the incoming item; the price word rides along untouched.
	assign in_rec = '{
		author_high: in_author_high,
		author_low:  in_author_low,
		title_high:  in_title_high,
		title_low:   in_title_low,
		price_bits:  in_price_bits
	};

	// Controller: counts the set in, walks the exchange sort (outer index j,
	// inner index h), then reads the sorted set out in order.
	res_ctrl #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_of_set(last_of_set),
		.busy       (busy),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr)
	);

	// Datapath: the record store, the held record for position j, the key
	// comparator and the output register.
	res_datapath #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.in_rec   (in_rec),
		.out_rec  (out_rec),
		.out_valid(valid),
		.out_last (last_out)
	);

	assign out_author_high = out_rec.author_high;
	assign out_author_low  = out_rec.author_low;
	assign out_title_high  = out_rec.title_high;
	assign out_title_low   = out_rec.title_low;
	assign out_price_bits  = out_rec.price_bits;

endmodule
